// ===== design/psfp_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and tables for the polar stereographic projection unit
// no dependencies

package psfp_pkg;

  // cordic rotations run, capped at the length of the arctangent table
  localparam int CORDIC_STAGES = 24;
  localparam int ATAN_LEN      = 40;
  localparam int CORDIC_RUN    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  localparam int CS_W  = 33;  // cordic sine / cosine result width
  localparam int CX_W  = 34;  // cordic internal x / y width
  localparam int CZ_W  = 33;  // cordic residual angle width
  localparam int QBITS = 33;  // quotient bits produced by the divider
  localparam int NN_W  = 63;  // rounded numerator width
  localparam int UD_W  = 39;  // divisor width

  localparam logic signed [CX_W-1:0] CORDIC_GAIN_INV = 34'sh0_26DD_3B6A;

  // reciprocals for division by 45
  localparam logic [24:0] RECIP_LAT  = 25'd23860930;  // ceil(2^30 / 45)
  localparam logic [26:0] RECIP_LON  = 27'd95443718;  // ceil(2^32 / 45)
  localparam logic [19:0] RECIP_FRAC = 20'd745655;    // ceil(2^25 / 45)

  localparam logic [28:0] RAD_NUM = 29'd407757056;
  localparam logic [6:0]  RAD_DEN = 7'd125;

  localparam logic [31:0] NUDGE_FULL  = 32'd68357;
  localparam logic [31:0] NUDGE_HALF  = 32'd34178;
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
  localparam logic [30:0] SCALE_ONE   = 31'h4000_0000;

  typedef enum logic [2:0] {
    REG_TANGENT_LON = 3'd0,
    REG_NORTH_POLE  = 3'd1,
    REG_SCALE       = 3'd2,
    REG_EASTING     = 3'd3,
    REG_NORTHING    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic lat_neg;
    logic d_neg;
    logic near_s;
    logic far_pos;
    logic far_neg;
  } ang_flags_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
  } scale_sign_t;

  typedef struct packed {
    logic             ovf;
    logic             neg;
    logic [QBITS-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } clamp_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051E;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2F;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2FA;
      15: r = 32'h0000_517D;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A30;
      19: r = 32'h0000_0518;
      20: r = 32'h0000_028C;
      21: r = 32'h0000_0146;
      22: r = 32'h0000_00A3;
      23: r = 32'h0000_0051;
      24: r = 32'h0000_0029;
      25: r = 32'h0000_0014;
      26: r = 32'h0000_000A;
      27: r = 32'h0000_0005;
      28: r = 32'h0000_0003;
      29: r = 32'h0000_0001;
      30: r = 32'h0000_0001;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // signed quotient plus offset, clipped to 32 bits
  function automatic clamp_t clamp_out(input div_res_t r, input logic signed [31:0] off);
    logic signed [34:0] qs;
    logic signed [35:0] sum;
    clamp_t             c;
    qs  = r.neg ? -$signed({2'b00, r.q}) : $signed({2'b00, r.q});
    sum = 36'(qs) + 36'(off);
    c.sat = 1'b0;
    c.val = sum[31:0];
    if (r.ovf) begin
      c.sat = 1'b1;
      c.val = r.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (sum > 36'sh0_7FFF_FFFF) begin
      c.sat = 1'b1;
      c.val = 32'sh7FFF_FFFF;
    end else if (sum < -36'sh0_8000_0000) begin
      c.sat = 1'b1;
      c.val = 32'sh8000_0000;
    end
    return c;
  endfunction

endpackage

// ===== design/polar_stereo_forward_projection_unit.sv =====
`timescale 1ns / 1ps
// polar stereographic forward projection: angle stages, two cordics, scale stages, dividers
// and the output register in turn; throughput one item per cycle, set by the fully
// pipelined cordic and one-bit-per-stage divider, the whole pipe halting while out is stalled
// reset clears all valid bits and loads tangent longitude 0, north aspect, scale 1.0
// and zero x and y offsets; no clearing pass, items accepted right after reset
// depends on psfp_pkg, psfp_angle, psfp_cordic, psfp_scale, psfp_div

module polar_stereo_forward_projection_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wr_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] lat_deg,
  input  logic signed [24:0] lon_deg,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic               saturated
);

  // configuration registers
  logic signed [24:0] tangent_longitude;
  logic               north_pole;
  logic [30:0]        scale_q30;
  logic signed [31:0] x_offset;
  logic signed [31:0] y_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      tangent_longitude <= '0;
      north_pole        <= 1'b1;
      scale_q30         <= psfp_pkg::SCALE_ONE;
      x_offset          <= '0;
      y_offset          <= '0;
    end else if (cfg_wr_en) begin
      case (psfp_pkg::cfg_reg_t'(cfg_index))
        psfp_pkg::REG_TANGENT_LON: tangent_longitude <= cfg_wr_data[24:0];
        psfp_pkg::REG_NORTH_POLE:  north_pole        <= cfg_wr_data[0];
        psfp_pkg::REG_SCALE:       scale_q30         <= cfg_wr_data[30:0];
        psfp_pkg::REG_EASTING:     x_offset          <= cfg_wr_data;
        psfp_pkg::REG_NORTHING:    y_offset          <= cfg_wr_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // zero scale stands for unity
  logic [30:0] scale_eff;
  assign scale_eff = (scale_q30 == '0) ? psfp_pkg::SCALE_ONE : scale_q30;

  // one shared advance for every stage: the pipe moves unless the output register is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // angle front end: five stages
  logic        ang_valid;
  logic [31:0] theta_t, theta_d;

  psfp_angle u_angle (
    .clk               (clk),
    .rst               (rst),
    .en                (adv),
    .in_valid          (in_valid),
    .lat_deg           (lat_deg),
    .lon_deg           (lon_deg),
    .tangent_longitude (tangent_longitude),
    .north_pole        (north_pole),
    .out_valid         (ang_valid),
    .theta_t           (theta_t),
    .theta_d           (theta_d)
  );

  // two cordics side by side: colatitude term and longitude difference
  logic cor_t_valid, cor_d_valid;
  logic signed [psfp_pkg::CS_W-1:0] ct, st, cd, sd;

  psfp_cordic u_cordic_t (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ang_valid),
    .ang       (theta_t),
    .out_valid (cor_t_valid),
    .co        (ct),
    .si        (st)
  );

  psfp_cordic u_cordic_d (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ang_valid),
    .ang       (theta_d),
    .out_valid (cor_d_valid),
    .co        (cd),
    .si        (sd)
  );

  // products and divider operands: five stages
  logic                             scl_valid;
  logic [psfp_pkg::NN_W-1:0]        nn_x, nn_y;
  logic [psfp_pkg::UD_W-1:0]        ud;
  psfp_pkg::scale_sign_t            sign;

  psfp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (cor_t_valid && cor_d_valid),
    .scale      (scale_eff),
    .north_pole (north_pole),
    .ct         (ct),
    .st         (st),
    .cd         (cd),
    .sd         (sd),
    .out_valid  (scl_valid),
    .nn_x       (nn_x),
    .nn_y       (nn_y),
    .ud         (ud),
    .sign       (sign)
  );

  // rounding division by 125 * cos, one per axis
  logic               div_x_valid, div_y_valid;
  psfp_pkg::div_res_t res_x, res_y;

  psfp_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (scl_valid),
    .nn        (nn_x),
    .ud        (ud),
    .neg       (sign.neg_x),
    .out_valid (div_x_valid),
    .res       (res_x)
  );

  psfp_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (scl_valid),
    .nn        (nn_y),
    .ud        (ud),
    .neg       (sign.neg_y),
    .out_valid (div_y_valid),
    .res       (res_y)
  );

  // offsets, clipping and the output register
  psfp_pkg::clamp_t cx, cy;

  always_comb begin
    cx = psfp_pkg::clamp_out(res_x, x_offset);
    cy = psfp_pkg::clamp_out(res_y, y_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_x_valid && div_y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_pos     <= cx.val;
      y_pos     <= cy.val;
      saturated <= cx.sat || cy.sat;
    end
  end

  // a clipped item always carries at least one coordinate at a range limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (x_pos == 32'sh7FFF_FFFF || x_pos == 32'sh8000_0000 ||
                                y_pos == 32'sh7FFF_FFFF || y_pos == 32'sh8000_0000))
    else $error("saturated flag without a clipped coordinate");

  // nothing comes out straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held output freezes the divider tail
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(res_x) && $stable(res_y) && $stable(div_x_valid))
    else $error("pipeline moved during a stall");

  // both axes keep step through the dividers
  assert property (@(posedge clk) disable iff (rst) div_x_valid == div_y_valid)
    else $error("divider valid bits out of step");

endmodule

// ===== design/psfp_angle.sv =====
`timescale 1ns / 1ps
// input stages: degrees to turn units, rounding division by 45, pole and meridian nudges
// depends on psfp_pkg

module psfp_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [23:0] lat_deg,
  input  logic signed [24:0] lon_deg,
  input  logic signed [24:0] tangent_longitude,
  input  logic               north_pole,
  output logic               out_valid,
  output logic [31:0]        theta_t,
  output logic [31:0]        theta_d
);

  logic [4:0] vld;

  // stage 1
  logic signed [25:0] d;
  logic signed [24:0] lat_off;
  psfp_pkg::ang_flags_t flg_in, flg_1, flg_2, flg_3, flg_4;
  logic [23:0] abs_lat_in, abs_lat_1, abs_lat_2;
  logic [25:0] abs_d_in, abs_d_1, abs_d_2;

  assign d       = $signed({lon_deg[24], lon_deg}) - $signed({tangent_longitude[24], tangent_longitude});
  assign lat_off = $signed({lat_deg[23], lat_deg}) + 25'sd5898240;

  always_comb begin
    flg_in.lat_neg = lat_deg[23];
    flg_in.d_neg   = d[25];
    flg_in.near_s  = (lat_off >= -25'sd375) && (lat_off <= 25'sd375);
    flg_in.far_pos = (d >= 26'sd11796105) && (d <= 26'sd11796855);
    flg_in.far_neg = (d >= -26'sd11796855) && (d <= -26'sd11796105);
    abs_lat_in     = lat_deg[23] ? (~lat_deg + 24'd1) : lat_deg;
    abs_d_in       = d[25] ? (~d + 26'd1) : d;
  end

  // stage 2: integer quotient by 45
  logic [48:0] prod_l;
  logic [52:0] prod_d;
  logic [17:0] ql_2, ql_3;
  logic [19:0] qd_2, qd_3;

  assign prod_l = 49'(abs_lat_1) * 49'(psfp_pkg::RECIP_LAT);
  assign prod_d = 53'(abs_d_1) * 53'(psfp_pkg::RECIP_LON);

  // stage 3: remainder, scaled and half-divisor added
  logic [23:0] rem_l;
  logic [25:0] rem_d;
  logic [17:0] tl_3;
  logic [18:0] td_3;

  assign rem_l = abs_lat_2 - (24'(ql_2) * 24'd45);
  assign rem_d = abs_d_2 - (26'(qd_2) * 26'd45);

  // stage 4: fractional quotient
  logic [37:0] prod_fl;
  logic [38:0] prod_fd;
  logic [29:0] mag_l_4;
  logic [31:0] mag_d_4;

  assign prod_fl = 38'(tl_3) * 38'(psfp_pkg::RECIP_FRAC);
  assign prod_fd = 39'(td_3) * 39'(psfp_pkg::RECIP_FRAC);

  // stage 5: sign, nudges and cordic angles, all mod one turn
  logic [31:0] hmag, hl, dl;

  always_comb begin
    hmag = {2'b00, mag_l_4};
    hl   = (flg_4.lat_neg ? -hmag : hmag) + (flg_4.near_s ? psfp_pkg::NUDGE_HALF : 32'd0);
    dl   = (flg_4.d_neg ? -mag_d_4 : mag_d_4)
         + (flg_4.far_neg ? psfp_pkg::NUDGE_FULL : 32'd0)
         - (flg_4.far_pos ? psfp_pkg::NUDGE_FULL : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_1     <= flg_in;
      abs_lat_1 <= abs_lat_in;
      abs_d_1   <= abs_d_in;
      flg_2     <= flg_1;
      abs_lat_2 <= abs_lat_1;
      abs_d_2   <= abs_d_1;
      ql_2      <= prod_l[47:30];
      qd_2      <= prod_d[51:32];
      flg_3     <= flg_2;
      ql_3      <= ql_2;
      qd_3      <= qd_2;
      tl_3      <= {rem_l[5:0], 12'd0} + 18'd22;
      td_3      <= {rem_d[5:0], 13'd0} + 19'd22;
      flg_4     <= flg_3;
      mag_l_4   <= {ql_3, prod_fl[36:25]};
      mag_d_4   <= {qd_3[18:0], prod_fd[37:25]};
      theta_t   <= north_pole ? (psfp_pkg::EIGHTH_TURN - hl) : (psfp_pkg::EIGHTH_TURN + hl);
      theta_d   <= dl;
    end
  end

  assign out_valid = vld[4];

endmodule

// ===== design/psfp_cordic.sv =====
`timescale 1ns / 1ps
// pipelined rotation cordic giving cosine and sine in q30, one rotation per stage
// depends on psfp_pkg

module psfp_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [31:0]                          ang,
  output logic                                 out_valid,
  output logic signed [psfp_pkg::CS_W-1:0]     co,
  output logic signed [psfp_pkg::CS_W-1:0]     si
);

  localparam int N = psfp_pkg::CORDIC_RUN;

  logic [N+1:0] vld;
  logic signed [psfp_pkg::CX_W-1:0] xs [1:N];
  logic signed [psfp_pkg::CX_W-1:0] ys [1:N];
  logic signed [psfp_pkg::CZ_W-1:0] zs [0:N];
  logic [1:0] qs [0:N];

  // take out the nearest quarter turn
  logic [31:0] ang_rot, red;
  logic [1:0]  quad;

  assign ang_rot = ang + psfp_pkg::EIGHTH_TURN;
  assign quad    = ang_rot[31:30];
  assign red     = ang - {quad, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= $signed({red[31], red});
      qs[0] <= quad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [psfp_pkg::CX_W-1:0] xin, yin, dx, dy;
    logic signed [psfp_pkg::CZ_W-1:0] step;
    if (i == 0) begin : g_first
      assign xin = psfp_pkg::CORDIC_GAIN_INV;
      assign yin = '0;
    end else begin : g_next
      assign xin = xs[i];
      assign yin = ys[i];
    end
    assign dx   = yin >>> i;
    assign dy   = xin >>> i;
    assign step = $signed({1'b0, psfp_pkg::atan_turn(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][psfp_pkg::CZ_W-1]) begin
          xs[i+1] <= xin - dx;
          ys[i+1] <= yin + dy;
          zs[i+1] <= zs[i] - step;
        end else begin
          xs[i+1] <= xin + dx;
          ys[i+1] <= yin - dy;
          zs[i+1] <= zs[i] + step;
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  // put the quarter turn back
  logic signed [psfp_pkg::CX_W-1:0] co_c, si_c;

  always_comb begin
    case (qs[N])
      2'd0: begin
        co_c = xs[N];
        si_c = ys[N];
      end
      2'd1: begin
        co_c = -ys[N];
        si_c = xs[N];
      end
      2'd2: begin
        co_c = -xs[N];
        si_c = -ys[N];
      end
      default: begin
        co_c = ys[N];
        si_c = -xs[N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co <= co_c[psfp_pkg::CS_W-1:0];
      si <= si_c[psfp_pkg::CS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N:0], in_valid};
    end
  end

  assign out_valid = vld[N+1];

endmodule

// ===== design/psfp_scale.sv =====
`timescale 1ns / 1ps
// scale and rotation products, magnitudes, rounded numerator and divisor for the divider
// depends on psfp_pkg

module psfp_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [30:0]                        scale,
  input  logic                               north_pole,
  input  logic signed [psfp_pkg::CS_W-1:0]   ct,
  input  logic signed [psfp_pkg::CS_W-1:0]   st,
  input  logic signed [psfp_pkg::CS_W-1:0]   cd,
  input  logic signed [psfp_pkg::CS_W-1:0]   sd,
  output logic                               out_valid,
  output logic [psfp_pkg::NN_W-1:0]          nn_x,
  output logic [psfp_pkg::NN_W-1:0]          nn_y,
  output logic [psfp_pkg::UD_W-1:0]          ud,
  output psfp_pkg::scale_sign_t              sign
);

  logic [4:0] vld;

  // stage a: scaled tangent numerator
  logic signed [64:0] prod_a;
  logic signed [33:0] a_a;
  logic signed [psfp_pkg::CS_W-1:0] ct_a, cd_a, sd_a;

  assign prod_a = $signed({1'b0, scale}) * st;

  // stage b: rotate by the longitude difference
  logic signed [66:0] prod_bx, prod_by;
  logic signed [33:0] bx_b, by_b;
  logic signed [psfp_pkg::CS_W-1:0] ct_b;

  assign prod_bx = a_a * sd_a;
  assign prod_by = a_a * cd_a;

  // stage c: magnitudes and signs
  logic signed [psfp_pkg::CS_W-1:0] ct_nz;
  logic [32:0] abs_bx_c, abs_by_c;
  logic [31:0] abs_ct_c;
  logic        bx_neg_c, by_neg_c, ct_neg_c;
  logic [33:0] nbx, nby;
  logic [psfp_pkg::CS_W-1:0] nct;

  always_comb begin
    ct_nz = (ct_b == '0) ? psfp_pkg::CS_W'(1) : ct_b;
    nbx   = -bx_b;
    nby   = -by_b;
    nct   = -ct_nz;
  end

  // stage d: partial products of the radius term, divisor
  logic [45:0] pl_x_d, pl_y_d;
  logic [44:0] ph_x_d, ph_y_d;
  logic [psfp_pkg::UD_W-1:0] ud_d;
  psfp_pkg::scale_sign_t sign_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a  <= prod_a[63:30];
      ct_a <= ct;
      cd_a <= cd;
      sd_a <= sd;

      bx_b <= prod_bx[63:30];
      by_b <= north_pole ? -prod_by[63:30] : prod_by[63:30];
      ct_b <= ct_a;

      bx_neg_c <= bx_b[33];
      by_neg_c <= by_b[33];
      ct_neg_c <= ct_nz[psfp_pkg::CS_W-1];
      abs_bx_c <= bx_b[33] ? nbx[32:0] : bx_b[32:0];
      abs_by_c <= by_b[33] ? nby[32:0] : by_b[32:0];
      abs_ct_c <= ct_nz[psfp_pkg::CS_W-1] ? nct[31:0] : ct_nz[31:0];

      pl_x_d       <= 46'(abs_bx_c[16:0]) * 46'(psfp_pkg::RAD_NUM);
      ph_x_d       <= 45'(abs_bx_c[32:17]) * 45'(psfp_pkg::RAD_NUM);
      pl_y_d       <= 46'(abs_by_c[16:0]) * 46'(psfp_pkg::RAD_NUM);
      ph_y_d       <= 45'(abs_by_c[32:17]) * 45'(psfp_pkg::RAD_NUM);
      ud_d         <= psfp_pkg::UD_W'(abs_ct_c) * psfp_pkg::UD_W'(psfp_pkg::RAD_DEN);
      sign_d.neg_x <= bx_neg_c ^ ct_neg_c;
      sign_d.neg_y <= by_neg_c ^ ct_neg_c;

      // stage e: magnitude numerator plus half divisor for nearest rounding
      nn_x <= psfp_pkg::NN_W'(pl_x_d) + (psfp_pkg::NN_W'(ph_x_d) << 17)
            + psfp_pkg::NN_W'(ud_d >> 1);
      nn_y <= psfp_pkg::NN_W'(pl_y_d) + (psfp_pkg::NN_W'(ph_y_d) << 17)
            + psfp_pkg::NN_W'(ud_d >> 1);
      ud   <= ud_d;
      sign <= sign_d;
    end
  end

  assign out_valid = vld[4];

endmodule

// ===== design/psfp_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, with an overflow check up front
// depends on psfp_pkg

module psfp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [psfp_pkg::NN_W-1:0]     nn,
  input  logic [psfp_pkg::UD_W-1:0]     ud,
  input  logic                          neg,
  output logic                          out_valid,
  output psfp_pkg::div_res_t            res
);

  localparam int QB = psfp_pkg::QBITS;
  localparam int CW = psfp_pkg::UD_W + QB;

  logic [QB:0] vld;
  logic [psfp_pkg::NN_W-1:0] rem [0:QB-1];
  logic [psfp_pkg::UD_W-1:0] udr [0:QB-1];
  logic [QB-1:0] q [0:QB];
  logic          sgn [0:QB];
  logic          ovf [0:QB];

  // quotient would not fit the bits below: result clips anyway
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nn;
      udr[0] <= ud;
      q[0]   <= '0;
      sgn[0] <= neg;
      ovf[0] <= CW'(nn) >= {ud, {QB{1'b0}}};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [CW-1:0] shifted;
    logic          take;
    assign shifted = CW'(udr[k]) << (QB - 1 - k);
    assign take    = CW'(rem[k]) >= shifted;
    always_ff @(posedge clk) begin
      if (en) begin
        q[k+1]   <= {q[k][QB-2:0], take};
        sgn[k+1] <= sgn[k];
        ovf[k+1] <= ovf[k];
      end
    end
    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= take ? (rem[k] - shifted[psfp_pkg::NN_W-1:0]) : rem[k];
          udr[k+1] <= udr[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  always_comb begin
    res.ovf = ovf[QB];
    res.neg = sgn[QB];
    res.q   = q[QB];
  end

  assign out_valid = vld[QB];

endmodule
